@@ hw/rtl/polyev_pkg.sv @@
// ----------------------------------------------------------------------------
// Polynomial evaluator package
// Widths, request codes and defaults that the evaluator uses.
// ----------------------------------------------------------------------------
package polyev_pkg;

	// Default number of coefficient entries (powers 0 to MAX_TERMS-1).
	localparam int MAX_TERMS_DEF = 16;

	// Signed Q16.16 word width.
	localparam int Q_W = 32;

	// Field widths of the request and configuration beats.
	localparam int IDX_W = 4;
	localparam int DEG_W = 4;

	// Width that holds any index or table size up to 256 without loss.
	localparam int IDX_EXT_W = 9;

	// Request type codes.
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_EVAL  = 1'b1;

endpackage

@@ hw/rtl/polynomial_evaluator.sv @@
// ----------------------------------------------------------------------------
// Polynomial evaluator
// Evaluates a stored polynomial in signed Q16.16 by Horner's rule.
// ----------------------------------------------------------------------------
// Usage:
// A request beat on the input channel (in_valid / in_stall) either writes one
// coefficient (req_type write: coef_index, coef_value) or evaluates the
// polynomial at x_value (req_type evaluate). Every request gives exactly one
// result beat on the output channel (out_valid / out_stall): poly_value and
// overflow, both zero for a write.
// The degree register is written through the configuration channel
// (cfg_valid / cfg_ready / cfg_data); the user must write it only while no
// request is in flight, which the block itself does not enforce. An evaluation
// uses one shared 32x32 multiplier and one rounding adder once per power, each
// Horner step taking a multiply state and an add state, after one coefficient
// read at the start. One request is worked on at a time; in_stall is high
// until the result has moved into the output register.
// Reset clears the degree to zero and empties the output register; the
// coefficient table is not cleared and must be written before it is used.
// While the receiver stalls, the result beat holds in the output register.
// ----------------------------------------------------------------------------
module polynomial_evaluator #(
	parameter int MAX_TERMS = polyev_pkg::MAX_TERMS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,

	// Configuration channel.
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [polyev_pkg::DEG_W-1:0]     cfg_data,

	// Request channel.
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             req_type,
	input  logic [polyev_pkg::IDX_W-1:0]     coef_index,
	input  logic signed [polyev_pkg::Q_W-1:0] coef_value,
	input  logic signed [polyev_pkg::Q_W-1:0] x_value,

	// Result channel.
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [polyev_pkg::Q_W-1:0] poly_value,
	output logic                             overflow
);

	localparam int AW    = $clog2(MAX_TERMS);
	localparam int QW    = polyev_pkg::Q_W;
	localparam int EW    = polyev_pkg::IDX_EXT_W;
	localparam int PW    = 2 * QW;
	localparam int RW    = PW - 16;
	localparam int SW    = RW + 1;

	// Sequencer state codes.
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_ADD  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0]                  state_q;
	logic [polyev_pkg::DEG_W-1:0] degree_q;
	logic [AW-1:0]               cnt_q;
	logic signed [QW-1:0]        x_q;
	logic signed [QW-1:0]        acc_q;
	logic                        ovf_q;
	logic signed [PW-1:0]        prod_s1;
	logic                        out_valid_q;
	logic signed [QW-1:0]        out_value_q;
	logic                        out_ovf_q;

	logic                        in_take;
	logic                        out_free;
	logic [EW-1:0]               idx_ext;
	logic [EW-1:0]               deg_ext;
	logic [EW-1:0]               top_ext;
	logic [AW-1:0]               top_idx;
	logic                        wr_en;
	logic                        rd_en;
	logic [AW-1:0]               rd_addr;
	logic [QW-1:0]               rd_data;
	logic signed [PW-1:0]        prod_rnd;
	logic signed [RW-1:0]        rnd_val;
	logic signed [SW-1:0]        sum_val;
	logic signed [QW-1:0]        sat_val;
	logic                        sat_hit;

	// Handshakes.
	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	// Index widened and degree clamped to the last table entry.
	assign idx_ext = EW'(coef_index);
	assign deg_ext = EW'(degree_q);
	assign top_ext = (deg_ext >= EW'(MAX_TERMS)) ? EW'(MAX_TERMS - 1) : deg_ext;
	assign top_idx = top_ext[AW-1:0];

	// Coefficient table access: writes on accepted in-range write beats, reads as sequenced.
	assign wr_en = in_take && (req_type == polyev_pkg::REQ_WRITE)
		&& (idx_ext < EW'(MAX_TERMS));

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = top_idx;
		if (in_take && (req_type == polyev_pkg::REQ_EVAL)) begin
			rd_en   = 1'b1;
			rd_addr = top_idx;
		end else if ((state_q == ST_LOAD || state_q == ST_ADD) && (cnt_q != '0)) begin
			rd_en   = 1'b1;
			rd_addr = cnt_q - AW'(1);
		end
	end

	polyev_ram #(
		.WIDTH (QW),
		.DEPTH (MAX_TERMS)
	) u_coef_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (idx_ext[AW-1:0]),
		.wr_data (coef_value),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Round the Q32.32 product half up to Q16.16, add the coefficient and saturate.
	assign prod_rnd = prod_s1 + PW'(32768);
	assign rnd_val  = prod_rnd[PW-1:16];
	assign sum_val  = SW'(rnd_val) + SW'($signed(rd_data));

	always_comb begin
		sat_hit = 1'b0;
		sat_val = sum_val[QW-1:0];
		if (sum_val > SW'(signed'({1'b0, {(QW-1){1'b1}}}))) begin
			sat_hit = 1'b1;
			sat_val = {1'b0, {(QW-1){1'b1}}};
		end else if (sum_val < SW'(signed'({1'b1, {(QW-1){1'b0}}}))) begin
			sat_hit = 1'b1;
			sat_val = {1'b1, {(QW-1){1'b0}}};
		end
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			degree_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				degree_q <= cfg_data;
			end
			// The output register fills from the sequencer and empties on an accepted beat.
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						state_q <= (req_type == polyev_pkg::REQ_EVAL) ? ST_LOAD : ST_FIN;
					end
				end
				ST_LOAD: begin
					state_q <= (cnt_q == '0) ? ST_FIN : ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					state_q <= (cnt_q == '0) ? ST_FIN : ST_MUL;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: accumulator, counter, product and result beat.
	always_ff @(posedge clk) begin
		prod_s1 <= acc_q * x_q;
		case (state_q)
			ST_IDLE: begin
				if (in_take) begin
					cnt_q <= top_idx;
					x_q   <= x_value;
					acc_q <= '0;
					ovf_q <= 1'b0;
				end
			end
			ST_LOAD: begin
				acc_q <= rd_data;
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - AW'(1);
				end
			end
			ST_ADD: begin
				acc_q <= sat_val;
				ovf_q <= ovf_q | sat_hit;
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - AW'(1);
				end
			end
			ST_FIN: begin
				if (out_free) begin
					out_value_q <= acc_q;
					out_ovf_q   <= ovf_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid  = out_valid_q;
	assign poly_value = out_value_q;
	assign overflow   = out_ovf_q;

endmodule

@@ hw/rtl/polyev_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module polyev_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Storage write and registered read; the read data holds when no read is issued.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
